@@ sv/ourx_pkg.sv @@
`timescale 1ns / 1ps

package ourx_pkg;

    localparam int THRESHOLD_BITS = 12;
    localparam int TICK_BITS      = 16;
    localparam int BYTE_BITS      = 8;
    localparam int BIT_INDEX_BITS = 3;
    localparam int CFG_INDEX_BITS = 1;

    localparam logic [THRESHOLD_BITS-1:0] THRESHOLD_RESET = 12'd1100;
    localparam logic [TICK_BITS-1:0]      BIT_TICKS_RESET = 16'd3333;
    localparam logic [BIT_INDEX_BITS-1:0] LAST_BIT        = 3'd7;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_THRESHOLD = 1'b0,
        CFG_BIT_TICKS = 1'b1
    } cfg_index_t;

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_CONFIRM = 2'd1,
        PH_DATA    = 2'd2,
        PH_STOP    = 2'd3
    } phase_t;

    typedef struct packed {
        logic valid;
        logic advance;
        logic high;
    } step_t;

    typedef struct packed {
        logic                 emit;
        logic [BYTE_BITS-1:0] data_byte;
    } result_t;

endpackage

@@ sv/ourx_sample_if.sv @@
`timescale 1ns / 1ps

interface ourx_sample_if #(
    parameter int SAMPLE_BITS = 12
);
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink (input valid, input sample, output ready);
endinterface

@@ sv/ourx_byte_if.sv @@
`timescale 1ns / 1ps

interface ourx_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink (input valid, input data_byte, output ready);
endinterface

@@ sv/ourx_cfg_if.sv @@
`timescale 1ns / 1ps

interface ourx_cfg_if;
    logic        valid;
    logic        ready;
    logic [0:0]  index;
    logic [15:0] wdata;

    modport source (output valid, output index, output wdata, input ready);
    modport sink (input valid, input index, input wdata, output ready);
endinterface

@@ sv/ourx_frame.sv @@
`timescale 1ns / 1ps

module ourx_frame (
    input  logic              clk,
    input  logic              rst_n,
    input  ourx_pkg::step_t   step,
    input  logic [15:0]       bit_ticks,
    output ourx_pkg::result_t result
);
    import ourx_pkg::*;

    phase_t                    phase_reg, phase_next;
    logic [TICK_BITS-1:0]      tick_reg, tick_next;
    logic [BIT_INDEX_BITS-1:0] bit_index_reg, bit_index_next;
    logic [BYTE_BITS-1:0]      shift_reg, shift_next;

    logic [TICK_BITS-1:0] limit;
    logic [TICK_BITS:0]   tick_inc;
    logic                 done;

    always_comb
    begin
        if (phase_reg == PH_CONFIRM)
        begin
            limit = {1'b0, bit_ticks[TICK_BITS-1:1]};
        end
        else
        begin
            limit = bit_ticks;
        end
        tick_inc = {1'b0, tick_reg} + {{TICK_BITS{1'b0}}, 1'b1};
        done     = tick_inc >= {1'b0, limit};
    end

    // next state
    always_comb
    begin
        phase_next     = phase_reg;
        tick_next      = tick_reg;
        bit_index_next = bit_index_reg;
        shift_next     = shift_reg;
        if (step.advance)
        begin
            if (phase_reg != PH_IDLE)
            begin
                tick_next = done ? '0 : tick_inc[TICK_BITS-1:0];
            end
            case (phase_reg)
                PH_IDLE:
                begin
                    if (!step.high)
                    begin
                        phase_next = PH_CONFIRM;
                        tick_next  = '0;
                    end
                end
                PH_CONFIRM:
                begin
                    if (done)
                    begin
                        if (step.high)
                        begin
                            phase_next = PH_IDLE;
                        end
                        else
                        begin
                            phase_next     = PH_DATA;
                            bit_index_next = '0;
                            shift_next     = '0;
                        end
                    end
                end
                PH_DATA:
                begin
                    if (done)
                    begin
                        if (step.high)
                        begin
                            shift_next[bit_index_reg] = 1'b1;
                        end
                        if (bit_index_reg == LAST_BIT)
                        begin
                            phase_next     = PH_STOP;
                            bit_index_next = '0;
                        end
                        else
                        begin
                            bit_index_next = bit_index_reg + 3'd1;
                        end
                    end
                end
                PH_STOP:
                begin
                    if (done)
                    begin
                        phase_next = PH_IDLE;
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    // outputs
    always_comb
    begin
        result.emit      = step.valid && (phase_reg == PH_STOP) && done;
        result.data_byte = shift_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            tick_reg      <= '0;
            bit_index_reg <= '0;
            shift_reg     <= '0;
        end
        else
        begin
            phase_reg     <= phase_next;
            tick_reg      <= tick_next;
            bit_index_reg <= bit_index_next;
            shift_reg     <= shift_next;
        end
    end

    a_emit_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        result.emit |-> step.valid)
        else $error("byte emitted without a sample in the stage");

    a_hold_without_step: assert property (@(posedge clk) disable iff (!rst_n)
        !step.advance |=> $stable(phase_reg) && $stable(tick_reg) && $stable(shift_reg))
        else $error("frame state moved without a step");

    a_data_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_CONFIRM) && (phase_next == PH_DATA)
        |=> (bit_index_reg == '0) && (shift_reg == '0))
        else $error("data phase entered with stale bits");
endmodule

@@ sv/optical_uart_receiver.sv @@
`timescale 1ns / 1ps

// channel   dir  payload                      transfer when
// samples   in   sample [SAMPLE_BITS-1:0]     samples.valid && samples.ready
// bytes     out  data_byte [7:0]              bytes.valid && bytes.ready
// cfg       in   index [0:0], wdata [15:0]    cfg.valid && cfg.ready
//
// one sample per cycle sustained unless a due byte meets a stalled output; a sample is
// registered, then stepped through the frame counter and bit shifter, with a byte
// landing in the output register as the stop wait ends
// reset clears the frame state and loads threshold 1100, bit_ticks 3333
// a stalled output only blocks the sample stage when a byte is due to emit
// cfg is always ready

module optical_uart_receiver #(
    parameter int SAMPLE_BITS = 12
) (
    input  logic          clk,
    input  logic          rst_n,
    ourx_sample_if.sink   samples,
    ourx_byte_if.source   bytes,
    ourx_cfg_if.sink      cfg
);
    import ourx_pkg::*;

    localparam int CMP_BITS = (SAMPLE_BITS > THRESHOLD_BITS) ? SAMPLE_BITS : THRESHOLD_BITS;

    logic [THRESHOLD_BITS-1:0] threshold_reg;
    logic [TICK_BITS-1:0]      bit_ticks_reg;

    logic                   s1_valid_reg, s1_valid_next;
    logic [SAMPLE_BITS-1:0] s1_sample_reg;
    logic                   out_valid_reg, out_valid_next;
    logic [BYTE_BITS-1:0]   out_byte_reg;

    step_t   step;
    result_t result;
    logic    s1_advance;
    logic    in_xfer;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= THRESHOLD_RESET;
            bit_ticks_reg <= BIT_TICKS_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg_index_t'(cfg.index))
                CFG_THRESHOLD: threshold_reg <= cfg.wdata[THRESHOLD_BITS-1:0];
                CFG_BIT_TICKS: bit_ticks_reg <= cfg.wdata;
                default:       threshold_reg <= threshold_reg;
            endcase
        end
    end

    always_comb
    begin
        step.valid   = s1_valid_reg;
        step.high    = CMP_BITS'(s1_sample_reg) > CMP_BITS'(threshold_reg);
        s1_advance   = s1_valid_reg && !(result.emit && out_valid_reg && !bytes.ready);
        step.advance = s1_advance;
    end

    assign samples.ready = !s1_valid_reg || s1_advance;
    assign in_xfer       = samples.valid && samples.ready;

    ourx_frame u_frame (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .bit_ticks (bit_ticks_reg),
        .result    (result)
    );

    always_comb
    begin
        s1_valid_next = in_xfer ? 1'b1 : (s1_advance ? 1'b0 : s1_valid_reg);
        if (result.emit && s1_advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (bytes.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            s1_sample_reg <= samples.sample;
        end
        if (result.emit && s1_advance)
        begin
            out_byte_reg <= result.data_byte;
        end
    end

    assign bytes.valid     = out_valid_reg;
    assign bytes.data_byte = out_byte_reg;

    a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_advance |=> s1_valid_reg && $stable(s1_sample_reg))
        else $error("sample stage lost its item under stall");

    a_emit_lands: assert property (@(posedge clk) disable iff (!rst_n)
        result.emit && s1_advance |=> out_valid_reg)
        else $error("emitted byte did not reach the output register");

    a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> s1_valid_reg)
        else $error("accepted sample not in the stage");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !bytes.ready |-> !(result.emit && s1_advance))
        else $error("pending byte overwritten");
endmodule

@@ tb/tb_optical_uart_receiver.sv @@
`timescale 1ns / 1ps

module tb_optical_uart_receiver;

    import ourx_pkg::*;

    localparam int SAMPLE_BITS = 12;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 8;
    localparam int IDLE_PCT = 36;
    localparam int MIN_SAMPLES = 750;
    localparam int MIN_BYTES = 16;
    localparam int MIN_PHASES = 5;

    localparam logic [SAMPLE_BITS-1:0] OPENING [24] = '{
        // zero byte, stop bit low
        12'd0, 12'd1100, 12'd0, 12'd1100, 12'd0, 12'd5, 12'd1100, 12'd0, 12'd17,
        12'd1100, 12'd0,
        // false start
        12'd700, 12'd1101,
        // byte a5
        12'd0, 12'd1100, 12'd4095, 12'd0, 12'd1101, 12'd1100, 12'd3, 12'd2048,
        12'd1099, 12'd4095, 12'd4095
    };

    logic clk = 1'b0;
    logic rst_n;

    ourx_sample_if #(.SAMPLE_BITS(SAMPLE_BITS)) sample_ch ();
    ourx_byte_if byte_ch ();
    ourx_cfg_if cfg_ch ();

    optical_uart_receiver #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (sample_ch),
        .bytes   (byte_ch),
        .cfg     (cfg_ch)
    );

    // decoder copy: configuration and frame state
    logic [THRESHOLD_BITS-1:0] thr_level = THRESHOLD_RESET;
    logic [TICK_BITS-1:0]      period    = BIT_TICKS_RESET;
    phase_t                    rx_phase  = PH_IDLE;
    logic [TICK_BITS-1:0]      wait_ticks = '0;
    logic [BIT_INDEX_BITS-1:0] bit_pos   = '0;
    logic [BYTE_BITS-1:0]      shift_reg = '0;

    logic [SAMPLE_BITS-1:0] line_samples [$];
    logic [BYTE_BITS-1:0]   expected_bytes [$];
    int  samples_queued = 0;
    int  samples_taken = 0;
    int  bytes_decoded = 0;
    int  errors = 0;
    int  cycles = 0;
    bit  gaps_on = 1'b1;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic report_mismatch(string msg);
        $display("mismatch: %s", msg);
        errors++;
    endtask

    task automatic decode_sample(logic [SAMPLE_BITS-1:0] s);
        logic                 is_high;
        logic [TICK_BITS:0]   next_count;
        logic [TICK_BITS-1:0] limit;
        is_high = s > thr_level;
        if (rx_phase == PH_IDLE)
        begin
            if (!is_high)
            begin
                rx_phase = PH_CONFIRM;
                wait_ticks = '0;
            end
        end
        else
        begin
            limit = (rx_phase == PH_CONFIRM) ? (period >> 1) : period;
            next_count = wait_ticks + 17'd1;
            if (next_count < limit)
                wait_ticks = next_count[TICK_BITS-1:0];
            else
            begin
                wait_ticks = '0;
                case (rx_phase)
                    PH_CONFIRM:
                    begin
                        if (is_high)
                            rx_phase = PH_IDLE;
                        else
                        begin
                            rx_phase = PH_DATA;
                            bit_pos = '0;
                            shift_reg = '0;
                        end
                    end
                    PH_DATA:
                    begin
                        if (is_high)
                            shift_reg[bit_pos] = 1'b1;
                        if (bit_pos == LAST_BIT)
                        begin
                            rx_phase = PH_STOP;
                            bit_pos = '0;
                        end
                        else
                            bit_pos = bit_pos + 1'b1;
                    end
                    default:
                    begin
                        expected_bytes.push_back(shift_reg);
                        bytes_decoded++;
                        rx_phase = PH_IDLE;
                    end
                endcase
            end
        end
    endtask

    // sample driver
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            sample_ch.valid <= 1'b0;
            sample_ch.sample <= '0;
        end
        else
        begin
            if (sample_ch.valid && sample_ch.ready)
            begin
                decode_sample(sample_ch.sample);
                samples_taken++;
            end
            if (!sample_ch.valid || sample_ch.ready)
            begin
                if (line_samples.size() > 0 && !(gaps_on && $urandom_range(99) < IDLE_PCT))
                begin
                    sample_ch.valid <= 1'b1;
                    sample_ch.sample <= line_samples.pop_front();
                end
                else
                    sample_ch.valid <= 1'b0;
            end
        end
    end

    // byte monitor
    always @(posedge clk)
    begin : byte_monitor
        logic [BYTE_BITS-1:0] want;
        if (!rst_n)
            byte_ch.ready <= 1'b0;
        else
        begin
            if (byte_ch.valid && byte_ch.ready)
            begin
                if (expected_bytes.size() == 0)
                    report_mismatch($sformatf("unexpected byte %02h", byte_ch.data_byte));
                else
                begin
                    want = expected_bytes.pop_front();
                    if (byte_ch.data_byte !== want)
                        report_mismatch($sformatf("data_byte %02h, want %02h",
                                                  byte_ch.data_byte, want));
                end
            end
            byte_ch.ready <= !gaps_on || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic push_sample(logic [SAMPLE_BITS-1:0] s);
        line_samples.push_back(s);
        samples_queued++;
    endtask

    function automatic logic [SAMPLE_BITS-1:0] level_sample(logic hi);
        if (hi && thr_level != 12'hFFF)
            return 12'($urandom_range(4095, thr_level + 1));
        return 12'($urandom_range(thr_level, 0));
    endfunction

    function automatic int ticks_per_bit();
        return (period < 2) ? 1 : int'(period);
    endfunction

    task automatic queue_frame(logic [BYTE_BITS-1:0] value);
        int spb;
        spb = ticks_per_bit();
        repeat ($urandom_range(3, 0)) push_sample(level_sample(1'b1));
        repeat (spb) push_sample(level_sample(1'b0));
        for (int i = 0; i < BYTE_BITS; i++)
            repeat (spb) push_sample(level_sample(value[i]));
        repeat (spb) push_sample(level_sample($urandom_range(9, 0) != 0));
    endtask

    // wait for all transfers and results, then let the pipeline empty
    task automatic settle();
        while (samples_taken != samples_queued || expected_bytes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(cfg_index_t idx, logic [15:0] value);
        @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.wdata <= value;
        do @(negedge clk); while (!cfg_ch.ready);
        @(posedge clk);
        cfg_ch.valid <= 1'b0;
        case (idx)
            CFG_THRESHOLD: thr_level = value[THRESHOLD_BITS-1:0];
            CFG_BIT_TICKS: period = value;
            default: ;
        endcase
    endtask

    initial
    begin
        int          phase_no;
        int          roll;
        int          spb;
        logic [11:0] thr;
        logic [15:0] ticks;
        phase_no = 0;
        rst_n = 1'b0;
        sample_ch.valid = 1'b0;
        sample_ch.sample = '0;
        byte_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = CFG_THRESHOLD;
        cfg_ch.wdata = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        write_reg(CFG_BIT_TICKS, 16'd1);
        foreach (OPENING[i])
            push_sample(OPENING[i]);
        settle();

        while (samples_taken < MIN_SAMPLES || bytes_decoded < MIN_BYTES
               || phase_no < MIN_PHASES)
        begin
            roll = $urandom_range(99);
            if (roll < 8)
                thr = 12'd0;
            else if (roll < 16)
                thr = 12'hFFF;
            else
                thr = 12'($urandom_range(3900, 200));
            roll = $urandom_range(99);
            if (roll < 10)
                ticks = 16'($urandom_range(1, 0));
            else if (roll < 85)
                ticks = 16'($urandom_range(6, 2));
            else if (roll < 95)
                ticks = 16'($urandom_range(24, 7));
            else
                ticks = 16'hFFFF;
            case (phase_no)
                0:
                begin
                    thr = 12'd0;
                    ticks = 16'd3;
                end
                1:
                begin
                    thr = 12'hFFF;
                    ticks = 16'd2;
                end
                2: ticks = 16'hFFFF;
                3: ticks = 16'd0;
                default: ;
            endcase
            gaps_on = (phase_no != 4);
            settle();
            write_reg(CFG_THRESHOLD, {4'($urandom), thr});
            write_reg(CFG_BIT_TICKS, ticks);

            repeat ($urandom_range(10, 4))
            begin
                spb = ticks_per_bit();
                roll = $urandom_range(99);
                if (period > 24)
                    repeat ($urandom_range(24, 12)) push_sample(12'($urandom));
                else if (roll < 70)
                    queue_frame(8'($urandom));
                else if (roll < 85)
                    repeat ($urandom_range(8, 1)) push_sample(12'($urandom));
                else if (roll < 95)
                begin
                    // false start
                    push_sample(level_sample(1'b0));
                    repeat (spb) push_sample(level_sample(1'b1));
                end
                else
                    settle();
            end
            phase_no++;
        end

        settle();
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
